// File: rtl/core/rotary_encoder_button_event_decoder_top_macros.svh
// ----------------------------------------------------------------------------
// Rotary encoder button event decoder assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef ROTARY_ENCODER_BUTTON_EVENT_DECODER_TOP_MACROS_SVH
`define ROTARY_ENCODER_BUTTON_EVENT_DECODER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define REBD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define REBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/rebd_pkg.sv
// ----------------------------------------------------------------------------
// Rotary encoder button event decoder package
// Shared types, event codes and the encoder transition table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rebd_pkg;

	localparam int unsigned TDATA_W = 8;
	localparam int unsigned CNT_W   = 16;

	localparam logic [CNT_W-1:0] HOLD_TICKS_RESET = 16'd15000;
	localparam logic [CNT_W-1:0] CNT_MAX          = 16'hFFFF;

	typedef enum logic [2:0] {
		EV_NONE  = 3'd0,
		EV_LEFT  = 3'd1,
		EV_RIGHT = 3'd2,
		EV_PRESS = 3'd3,
		EV_HOLD  = 3'd4
	} event_t;

	// Packed so that a_now sits in bit 0, as on the input stream.
	typedef struct packed {
		logic button_now;
		logic b_before;
		logic a_before;
		logic b_now;
		logic a_now;
	} sample_t;

	// Indexed by {a_now, b_now, a_before, b_before}.
	function automatic event_t move_decode(input logic [3:0] sel);
		event_t ev;
		unique case (sel)
			4'd2, 4'd4, 4'd11, 4'd13: ev = EV_RIGHT;
			4'd3, 4'd7, 4'd8, 4'd14:  ev = EV_LEFT;
			default:                  ev = EV_NONE;
		endcase
		return ev;
	endfunction

endpackage

// File: rtl/core/rebd_in_stage.sv
// ----------------------------------------------------------------------------
// Rotary encoder button event decoder input stage
// Registers one input sample and releases it when the event stage advances.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rebd_in_stage (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [rebd_pkg::TDATA_W-1:0] s_tdata,
	input  logic                        advance,
	output logic                        valid_s1,
	output rebd_pkg::sample_t           sample_s1
);

	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sample_s1 <= rebd_pkg::sample_t'(s_tdata[4:0]);
		end
	end

endmodule

// File: rtl/core/rebd_event_core.sv
// ----------------------------------------------------------------------------
// Rotary encoder button event decoder core
// Decodes movement, tracks the button level and the hold counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rebd_event_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [rebd_pkg::CNT_W-1:0]    cfg_wr_data,
	input  logic                          advance,
	input  rebd_pkg::sample_t             sample_s1,
	output rebd_pkg::event_t              event_d
);

	logic [rebd_pkg::CNT_W-1:0] hold_ticks_q;
	logic                       button_last_q;
	logic [rebd_pkg::CNT_W-1:0] low_cnt_q;
	logic                       hold_armed_q;

	logic                       button_last_d;
	logic [rebd_pkg::CNT_W-1:0] low_cnt_d;
	logic [rebd_pkg::CNT_W-1:0] cnt_step;
	logic                       hold_armed_d;

	always_comb begin
		event_d       = rebd_pkg::move_decode({sample_s1.a_now, sample_s1.b_now,
			sample_s1.a_before, sample_s1.b_before});
		button_last_d = button_last_q;
		low_cnt_d     = low_cnt_q;
		hold_armed_d  = hold_armed_q;
		cnt_step      = '0;
		if (sample_s1.button_now != button_last_q) begin
			hold_armed_d  = 1'b1;
			button_last_d = sample_s1.button_now;
			event_d       = sample_s1.button_now ? rebd_pkg::EV_PRESS : rebd_pkg::EV_NONE;
		end else begin
			if (!sample_s1.button_now) begin
				cnt_step = (low_cnt_q == rebd_pkg::CNT_MAX) ? low_cnt_q
					: low_cnt_q + 1'b1;
			end
			low_cnt_d = cnt_step;
			if (cnt_step == hold_ticks_q && hold_armed_q) begin
				event_d      = rebd_pkg::EV_HOLD;
				hold_armed_d = 1'b0;
				low_cnt_d    = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q  <= rebd_pkg::HOLD_TICKS_RESET;
			button_last_q <= 1'b0;
			low_cnt_q     <= '0;
			hold_armed_q  <= 1'b1;
		end else begin
			if (cfg_wr_en) begin
				hold_ticks_q <= cfg_wr_data;
			end
			if (advance) begin
				button_last_q <= button_last_d;
				low_cnt_q     <= low_cnt_d;
				hold_armed_q  <= hold_armed_d;
			end
		end
	end

endmodule

// File: rtl/core/rebd_out_stage.sv
// ----------------------------------------------------------------------------
// Rotary encoder button event decoder output stage
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rebd_out_stage (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         valid_s1,
	input  rebd_pkg::event_t             event_d,
	output logic                         advance,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [rebd_pkg::TDATA_W-1:0] m_tdata
);

	logic             valid_s2;
	rebd_pkg::event_t event_s2;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(rebd_pkg::TDATA_W-3){1'b0}}, event_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_s2 <= event_d;
		end
	end

endmodule

// File: rtl/core/rotary_encoder_button_event_decoder_top.sv
// ----------------------------------------------------------------------------
// Rotary encoder button event decoder
// Turns encoder and push-button samples into left, right, press and hold.
// ----------------------------------------------------------------------------
// Usage:
// Each transaction on the slave stream is one sample tick; each one yields
// exactly one transaction on the master stream carrying the event code
// (none, left, right, press or hold), in the same order.
// A sample is registered on entry, decoded against the button state and the
// hold counter while it sits in the input register, and the result is
// registered on exit.
// Throughput is one sample per cycle while the receiver keeps m_tready high;
// the button and counter state are updated once per sample.
// cfg_wr_en writes the hold threshold in ticks; it should be written only
// while no sample is in flight.
// Reset clears both stages, sets the threshold to 15000, the remembered
// button level to low, the counter to zero and arms hold detection.
// When the receiver stalls, the result is held and one further sample is
// still accepted into the input register before s_tready falls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotary_encoder_button_event_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // 3'b0, button_now, b_before, a_before, b_now, a_now
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // 5'b0, event_code[2:0]
);

	logic              advance;
	logic              valid_s1;
	rebd_pkg::sample_t sample_s1;
	rebd_pkg::event_t  event_d;

	rebd_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.sample_s1 (sample_s1)
	);

	rebd_event_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.advance     (advance),
		.sample_s1   (sample_s1),
		.event_d     (event_d)
	);

	rebd_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.event_d  (event_d),
		.advance  (advance),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// File: rtl/core/rebd_checker.sv
// ----------------------------------------------------------------------------
// Rotary encoder button event decoder port checker
// Checks stream behaviour seen at the top-level ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rotary_encoder_button_event_decoder_top_macros.svh"

module rebd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_wr_en,
	input logic [15:0] cfg_wr_data,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata
);

	`REBD_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata), "Stalled result changed or vanished.")

	`REBD_ASSERT_SAME(a_code_range, clk, arst_n, m_tvalid,
		m_tdata[7:3] == 5'd0 && m_tdata[2:0] <= 3'(rebd_pkg::EV_HOLD),
		"Event code out of range.")

	`REBD_ASSERT_SAME(a_ready_when_empty, clk, arst_n, !m_tvalid, s_tready,
		"Input stalled while the output is empty.")

	`REBD_ASSERT_SAME(a_latency, clk, arst_n, $rose(m_tvalid),
		$past(s_tvalid && s_tready, 2), "Result appeared without a matching sample.")

endmodule

bind rotary_encoder_button_event_decoder_top rebd_checker u_rebd_checker (.*);
